### hw/rtl/dsrl_pkg.sv
// Shared types and constants for the drive speed ramp limiter.
// Used by the divider, the configuration block, the pipeline and the top level.
`timescale 1ns / 1ps

package dsrl_pkg;

  // Vehicle constants.
  localparam longint VEHICLE_MASS_G  = 50000;
  localparam longint WHEEL_RADIUS_UM = 50000;

  // Drive acceleration is torque * 10^6 * 2^16 / (radius * mass). The radius
  // divides 10^6 * 2^16 exactly, so it folds into one scale constant.
  localparam longint DRIVE_SCALE = (64'd1000000 * 64'd65536) / WHEEL_RADIUS_UM;

  // Friction deceleration is f * 980665 / 100000 (gravity 9.80665), reduced to
  // f * 196133 / 20000. The division is a right shift by 5 and then a
  // reciprocal multiplication for 625 that is exact for dividends below 2^29.
  localparam int FRIC_PROD_W    = 34;
  localparam int FRIC_SHIFT     = 5;
  localparam int FRIC_DIV_W     = FRIC_PROD_W - FRIC_SHIFT;
  localparam int FRIC_RCP_W     = 30;
  localparam int FRIC_RCP_SHIFT = 39;
  localparam logic [17:0]           FRIC_MUL = 18'd196133;
  localparam logic [FRIC_RCP_W-1:0] FRIC_RCP = 30'd879609303;

  // Field widths.
  localparam int SPEED_W  = 32;
  localparam int DT_W     = 16;
  localparam int CFG_W    = 20;
  localparam int FRIC_W   = 16;
  localparam int CFG_IDX_W = 4;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_LOAD_MASS   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_TORQUE = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FRICTION    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL_LIMIT = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_ACCEL   = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ANG_DECEL   = 4'd7;

  // Register reset values.
  localparam logic [CFG_W-1:0]  RST_LOAD_MASS    = 20'd0;
  localparam logic [CFG_W-1:0]  RST_DRIVE_TORQUE = 20'd10000;
  localparam logic [FRIC_W-1:0] RST_FRICTION     = 16'd3277;
  localparam logic [CFG_W-1:0]  RST_SPEED_LIMIT  = 20'd65536;
  localparam logic [CFG_W-1:0]  RST_ACCEL_LIMIT  = 20'd32768;
  localparam logic [CFG_W-1:0]  RST_DECEL_LIMIT  = 20'd32768;
  localparam logic [CFG_W-1:0]  RST_ANG_ACCEL    = 20'd65536;
  localparam logic [CFG_W-1:0]  RST_ANG_DECEL    = 20'd65536;

  // Drive divider: 20-bit torque times 21-bit scale, over a 21-bit mass.
  localparam int DIV_NUM_W = 41;
  localparam int DIV_DEN_W = 21;
  localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

  // Widths of the two derived accelerations.
  localparam int DRV_ACC_W  = 26;
  localparam int FRIC_ACC_W = 20;

  // Derived settings seen by the pipeline.
  typedef struct packed {
    logic             busy;
    logic [CFG_W-1:0] a_up;
    logic [CFG_W-1:0] a_dn;
    logic [CFG_W-1:0] speed_limit;
    logic [CFG_W-1:0] ang_up;
    logic [CFG_W-1:0] ang_dn;
  } cfg_view_t;

endpackage

### hw/rtl/dsrl_div.sv
// Restoring divider, one quotient bit per cycle, for the configuration block.
// Depends on dsrl_pkg for operand widths.
`timescale 1ns / 1ps

module dsrl_div import dsrl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic                 done,
  output logic [DIV_NUM_W-1:0] quo
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_NUM_W-1:0] num_nxt;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_DEN_W-1:0] rem_r;
  logic [DIV_DEN_W-1:0] rem_nxt;
  logic [DIV_DEN_W:0]   shifted;
  logic [DIV_DEN_W+1:0] diff;
  logic                 take;

  // The numerator register shifts out dividend bits and shifts in quotient bits.
  assign shifted = {rem_r, num_r[DIV_NUM_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, den_r};
  assign take    = !diff[DIV_DEN_W+1];
  assign rem_nxt = take ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
  assign num_nxt = {num_r[DIV_NUM_W-2:0], take};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= DIV_CNT_W'(DIV_NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DIV_CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= num_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = num_r;

endmodule

### hw/rtl/dsrl_cfg.sv
// Configuration registers and the sequencer that derives the linear
// acceleration limits from them. Depends on dsrl_pkg and dsrl_div.
`timescale 1ns / 1ps

module dsrl_cfg import dsrl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output cfg_view_t            view
);

  localparam logic [2:0] SEQ_IDLE     = 3'd0;
  localparam logic [2:0] SEQ_DRV_GO   = 3'd1;
  localparam logic [2:0] SEQ_DRV_RUN  = 3'd2;
  localparam logic [2:0] SEQ_FRIC_GO  = 3'd3;
  localparam logic [2:0] SEQ_FRIC_RUN = 3'd4;
  localparam logic [2:0] SEQ_MIX      = 3'd5;

  localparam int RCP_PROD_W = FRIC_DIV_W + FRIC_RCP_W;

  logic [CFG_W-1:0]  load_mass_r;
  logic [CFG_W-1:0]  drive_torque_r;
  logic [FRIC_W-1:0] friction_r;
  logic [CFG_W-1:0]  speed_limit_r;
  logic [CFG_W-1:0]  accel_limit_r;
  logic [CFG_W-1:0]  decel_limit_r;
  logic [CFG_W-1:0]  ang_accel_r;
  logic [CFG_W-1:0]  ang_decel_r;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  logic [DRV_ACC_W-1:0]   drive_acc_r;
  logic [FRIC_PROD_W-1:0] fric_prod_r;
  logic [FRIC_ACC_W-1:0]  fric_acc_r;
  logic [CFG_W-1:0]       a_up_r;
  logic [CFG_W-1:0]       a_dn_r;

  logic [DIV_NUM_W-1:0]  drv_num;
  logic [DIV_DEN_W-1:0]  mass;
  logic                  div_start;
  logic                  div_done;
  logic [DIV_NUM_W-1:0]  div_quo;
  logic [RCP_PROD_W-1:0] fric_rcp;

  logic [DRV_ACC_W-1:0] net_acc;
  logic [CFG_W-1:0]     a_up_nxt;
  logic [CFG_W-1:0]     a_dn_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_mass_r    <= RST_LOAD_MASS;
      drive_torque_r <= RST_DRIVE_TORQUE;
      friction_r     <= RST_FRICTION;
      speed_limit_r  <= RST_SPEED_LIMIT;
      accel_limit_r  <= RST_ACCEL_LIMIT;
      decel_limit_r  <= RST_DECEL_LIMIT;
      ang_accel_r    <= RST_ANG_ACCEL;
      ang_decel_r    <= RST_ANG_DECEL;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOAD_MASS:    load_mass_r    <= cfg_data;
        REG_DRIVE_TORQUE: drive_torque_r <= cfg_data;
        REG_FRICTION:     friction_r     <= cfg_data[FRIC_W-1:0];
        REG_SPEED_LIMIT:  speed_limit_r  <= cfg_data;
        REG_ACCEL_LIMIT:  accel_limit_r  <= cfg_data;
        REG_DECEL_LIMIT:  decel_limit_r  <= cfg_data;
        REG_ANG_ACCEL:    ang_accel_r    <= cfg_data;
        REG_ANG_DECEL:    ang_decel_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign mass      = DIV_DEN_W'(VEHICLE_MASS_G) + DIV_DEN_W'(load_mass_r);
  assign drv_num   = DIV_NUM_W'(drive_torque_r) * DIV_NUM_W'(DRIVE_SCALE);
  assign div_start = (state_r == SEQ_DRV_GO);

  dsrl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (drv_num),
    .den   (mass),
    .done  (div_done),
    .quo   (div_quo)
  );

  // The friction product is divided by 32 with the shift and by 625 with the
  // reciprocal multiplication.
  assign fric_rcp = RCP_PROD_W'(fric_prod_r[FRIC_PROD_W-1:FRIC_SHIFT]) *
                    RCP_PROD_W'(FRIC_RCP);

  // Any register write starts the derivation over from the start.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SEQ_IDLE:     state_nxt = SEQ_IDLE;
      SEQ_DRV_GO:   state_nxt = SEQ_DRV_RUN;
      SEQ_DRV_RUN:  if (div_done) state_nxt = SEQ_FRIC_GO;
      SEQ_FRIC_GO:  state_nxt = SEQ_FRIC_RUN;
      SEQ_FRIC_RUN: state_nxt = SEQ_MIX;
      SEQ_MIX:      state_nxt = SEQ_IDLE;
      default:      state_nxt = SEQ_DRV_GO;
    endcase
    if (cfg_valid) begin
      state_nxt = SEQ_DRV_GO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SEQ_DRV_GO;
    end else begin
      state_r <= state_nxt;
    end
  end

  // The drive quotient stays below 2^26 for every register value.
  assign net_acc  = (drive_acc_r > DRV_ACC_W'(fric_acc_r)) ?
                    drive_acc_r - DRV_ACC_W'(fric_acc_r) : '0;
  assign a_up_nxt = (net_acc > DRV_ACC_W'(accel_limit_r)) ?
                    accel_limit_r : net_acc[CFG_W-1:0];
  assign a_dn_nxt = (fric_acc_r > decel_limit_r) ? decel_limit_r : fric_acc_r;

  always_ff @(posedge clk) begin
    if (state_r == SEQ_DRV_RUN && div_done) begin
      drive_acc_r <= div_quo[DRV_ACC_W-1:0];
    end
    if (state_r == SEQ_FRIC_GO) begin
      fric_prod_r <= FRIC_PROD_W'(friction_r) * FRIC_PROD_W'(FRIC_MUL);
    end
    if (state_r == SEQ_FRIC_RUN) begin
      fric_acc_r <= fric_rcp[FRIC_RCP_SHIFT+FRIC_ACC_W-1:FRIC_RCP_SHIFT];
    end
    if (state_r == SEQ_MIX) begin
      a_up_r <= a_up_nxt;
      a_dn_r <= a_dn_nxt;
    end
  end

  assign view.busy        = (state_r != SEQ_IDLE);
  assign view.a_up        = a_up_r;
  assign view.a_dn        = a_dn_r;
  assign view.speed_limit = speed_limit_r;
  assign view.ang_up      = ang_accel_r;
  assign view.ang_dn      = ang_decel_r;

endmodule

### hw/rtl/dsrl_pipe.sv
// Five-stage datapath: direction and rate select, step multiply, add,
// range clamp, goal clamp. Depends on dsrl_pkg.
`timescale 1ns / 1ps

module dsrl_pipe import dsrl_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_view_t                 view,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [SPEED_W-1:0] in_speed_now,
  input  logic signed [SPEED_W-1:0] in_speed_goal,
  input  logic signed [SPEED_W-1:0] in_turn_rate_now,
  input  logic signed [SPEED_W-1:0] in_turn_rate_goal,
  input  logic [DT_W-1:0]           in_time_step,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SPEED_W-1:0] out_speed_next,
  output logic signed [SPEED_W-1:0] out_turn_rate_next
);

  localparam int SUM_W = SPEED_W + 1;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;
  logic adv1, adv2, adv3, adv4, adv5;
  logic take;

  // Stage 1: registered inputs, directions and selected rates.
  logic signed [SPEED_W-1:0] s1_lnow_r, s1_lgoal_r, s1_anow_r, s1_agoal_r;
  logic [DT_W-1:0]           s1_dt_r;
  logic                      s1_lup_r, s1_leq_r, s1_aup_r, s1_aeq_r;
  logic [CFG_W-1:0]          s1_lrate_r, s1_arate_r;
  logic                      lup, aup;

  // Stage 2: step sizes.
  logic signed [SPEED_W-1:0] s2_lnow_r, s2_lgoal_r, s2_anow_r, s2_agoal_r;
  logic                      s2_lup_r, s2_leq_r, s2_aup_r, s2_aeq_r;
  logic [CFG_W-1:0]          s2_lstep_r, s2_astep_r;
  logic [CFG_W+DT_W-1:0]     lprod, aprod;

  // Stage 3: stepped speeds.
  logic signed [SPEED_W-1:0] s3_lnow_r, s3_lgoal_r, s3_agoal_r;
  logic                      s3_lup_r, s3_leq_r, s3_aup_r, s3_aeq_r;
  logic signed [SUM_W-1:0]   s3_lsum_r, s3_asum_r;
  logic signed [SUM_W-1:0]   lnow_x, anow_x, lstep_x, astep_x;

  // Stage 4: linear range clamp, angular goal clamp.
  logic signed [SPEED_W-1:0] s4_lnow_r, s4_lgoal_r, s4_lclamp_r, s4_anext_r;
  logic                      s4_lup_r, s4_leq_r;
  logic signed [SPEED_W-1:0] lclamp, anext;
  logic signed [SUM_W-1:0]   agoal_x;

  // Stage 5: output register.
  logic signed [SPEED_W-1:0] s5_lnext_r, s5_anext_r;
  logic signed [SPEED_W-1:0] lnext;

  // A stage moves when it is empty or the stage after it moves.
  assign adv5 = !v5_r || out_ready;
  assign adv4 = !v4_r || adv5;
  assign adv3 = !v3_r || adv4;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;

  // No word enters while the derived limits are being recomputed.
  assign in_ready = adv1 && !view.busy;
  assign take     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (adv1) v1_r <= take;
      if (adv2) v2_r <= v1_r;
      if (adv3) v3_r <= v2_r;
      if (adv4) v4_r <= v3_r;
      if (adv5) v5_r <= v4_r;
    end
  end

  // Stage 1.
  assign lup = in_speed_goal > in_speed_now;
  assign aup = in_turn_rate_goal > in_turn_rate_now;

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_lnow_r  <= in_speed_now;
      s1_lgoal_r <= in_speed_goal;
      s1_anow_r  <= in_turn_rate_now;
      s1_agoal_r <= in_turn_rate_goal;
      s1_dt_r    <= in_time_step;
      s1_lup_r   <= lup;
      s1_leq_r   <= (in_speed_goal == in_speed_now);
      s1_aup_r   <= aup;
      s1_aeq_r   <= (in_turn_rate_goal == in_turn_rate_now);
      s1_lrate_r <= lup ? view.a_up : view.a_dn;
      s1_arate_r <= aup ? view.ang_up : view.ang_dn;
    end
  end

  // Stage 2.
  assign lprod = (CFG_W+DT_W)'(s1_lrate_r) * (CFG_W+DT_W)'(s1_dt_r);
  assign aprod = (CFG_W+DT_W)'(s1_arate_r) * (CFG_W+DT_W)'(s1_dt_r);

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_lnow_r  <= s1_lnow_r;
      s2_lgoal_r <= s1_lgoal_r;
      s2_anow_r  <= s1_anow_r;
      s2_agoal_r <= s1_agoal_r;
      s2_lup_r   <= s1_lup_r;
      s2_leq_r   <= s1_leq_r;
      s2_aup_r   <= s1_aup_r;
      s2_aeq_r   <= s1_aeq_r;
      s2_lstep_r <= lprod[CFG_W+DT_W-1:DT_W];
      s2_astep_r <= aprod[CFG_W+DT_W-1:DT_W];
    end
  end

  // Stage 3.
  assign lnow_x  = SUM_W'(s2_lnow_r);
  assign anow_x  = SUM_W'(s2_anow_r);
  assign lstep_x = $signed({{(SUM_W-CFG_W){1'b0}}, s2_lstep_r});
  assign astep_x = $signed({{(SUM_W-CFG_W){1'b0}}, s2_astep_r});

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_lnow_r  <= s2_lnow_r;
      s3_lgoal_r <= s2_lgoal_r;
      s3_agoal_r <= s2_agoal_r;
      s3_lup_r   <= s2_lup_r;
      s3_leq_r   <= s2_leq_r;
      s3_aup_r   <= s2_aup_r;
      s3_aeq_r   <= s2_aeq_r;
      s3_lsum_r  <= s2_lup_r ? lnow_x + lstep_x : lnow_x - lstep_x;
      if (s2_aeq_r) begin
        s3_asum_r <= anow_x;
      end else begin
        s3_asum_r <= s2_aup_r ? anow_x + astep_x : anow_x - astep_x;
      end
    end
  end

  // Stage 4.
  always_comb begin
    if (s3_lsum_r < 0) begin
      lclamp = '0;
    end else if (s3_lsum_r > $signed(SUM_W'(view.speed_limit))) begin
      lclamp = SPEED_W'(view.speed_limit);
    end else begin
      lclamp = s3_lsum_r[SPEED_W-1:0];
    end
  end

  assign agoal_x = SUM_W'(s3_agoal_r);

  always_comb begin
    if (s3_aup_r && s3_asum_r > agoal_x) begin
      anext = s3_agoal_r;
    end else if (!s3_aup_r && !s3_aeq_r && s3_asum_r < agoal_x) begin
      anext = s3_agoal_r;
    end else begin
      anext = s3_asum_r[SPEED_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      s4_lnow_r   <= s3_lnow_r;
      s4_lgoal_r  <= s3_lgoal_r;
      s4_lup_r    <= s3_lup_r;
      s4_leq_r    <= s3_leq_r;
      s4_lclamp_r <= lclamp;
      s4_anext_r  <= anext;
    end
  end

  // Stage 5: an equal goal returns the speed untouched by any clamp.
  always_comb begin
    if (s4_leq_r) begin
      lnext = s4_lnow_r;
    end else if (s4_lup_r && s4_lclamp_r > s4_lgoal_r) begin
      lnext = s4_lgoal_r;
    end else if (!s4_lup_r && s4_lclamp_r < s4_lgoal_r) begin
      lnext = s4_lgoal_r;
    end else begin
      lnext = s4_lclamp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv5) begin
      s5_lnext_r <= lnext;
      s5_anext_r <= s4_anext_r;
    end
  end

  assign out_valid          = v5_r;
  assign out_speed_next     = s5_lnext_r;
  assign out_turn_rate_next = s5_anext_r;

endmodule

### hw/rtl/drive_speed_ramp_limiter.sv
// Top level of the drive speed ramp limiter: configuration block and datapath.
// Depends on dsrl_pkg, dsrl_cfg and dsrl_pipe.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+---------------------------------------
//   in      | input     | in_valid / in_ready   | speed_now, speed_goal, turn rates, dt
//   out     | output    | out_valid / out_ready | speed_next, turn_rate_next
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One word per cycle is accepted unless the limits are being derived or a stalled
// output has filled the pipe. After reset and after every register write, in_ready
// stays low while a 41-step division derives the drive acceleration, two multiply
// steps the friction deceleration and one more step the combined limits.
// Register writes are always taken. A stalled output holds the pipe; empty
// stages still fill behind it.
`timescale 1ns / 1ps

module drive_speed_ramp_limiter import dsrl_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [SPEED_W-1:0] in_speed_now,
  input  logic signed [SPEED_W-1:0] in_speed_goal,
  input  logic signed [SPEED_W-1:0] in_turn_rate_now,
  input  logic signed [SPEED_W-1:0] in_turn_rate_goal,
  input  logic [DT_W-1:0]           in_time_step,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SPEED_W-1:0] out_speed_next,
  output logic signed [SPEED_W-1:0] out_turn_rate_next,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  cfg_view_t view;

  assign cfg_ready = 1'b1;

  dsrl_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .view      (view)
  );

  dsrl_pipe u_pipe (
    .clk                (clk),
    .rst_n              (rst_n),
    .view               (view),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_speed_now       (in_speed_now),
    .in_speed_goal      (in_speed_goal),
    .in_turn_rate_now   (in_turn_rate_now),
    .in_turn_rate_goal  (in_turn_rate_goal),
    .in_time_step       (in_time_step),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_speed_next     (out_speed_next),
    .out_turn_rate_next (out_turn_rate_next)
  );

endmodule

### hw/rtl/dsrl_chk.sv
// Port-level checker for the drive speed ramp limiter, bound to the top level.
// Depends on dsrl_pkg for port widths.
`timescale 1ns / 1ps

module dsrl_chk import dsrl_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic signed [SPEED_W-1:0] in_speed_now,
  input logic signed [SPEED_W-1:0] in_speed_goal,
  input logic signed [SPEED_W-1:0] in_turn_rate_now,
  input logic signed [SPEED_W-1:0] in_turn_rate_goal,
  input logic [DT_W-1:0]           in_time_step,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [SPEED_W-1:0] out_speed_next,
  input logic signed [SPEED_W-1:0] out_turn_rate_next,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic [CFG_IDX_W-1:0]      cfg_index,
  input logic [CFG_W-1:0]          cfg_data
);

  // Reset empties the pipe.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word present right after reset");

  // Reset starts the limit derivation, so no word may enter.
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> !in_ready)
    else $error("input accepted while limits are derived after reset");

  // A register write restarts the derivation.
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("input accepted right after a register write");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_speed_next)
      && $stable(out_turn_rate_next))
    else $error("stalled output word changed or dropped");

endmodule

bind drive_speed_ramp_limiter dsrl_chk u_dsrl_chk (.*);
